[rtl/core/apts_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the task scheduler.
`timescale 1ns / 1ps
package apts_pkg;

	localparam int TASKS   = 16;
	localparam int SLOT_W  = $clog2(TASKS);
	localparam int CNT_W   = $clog2(TASKS + 1);
	localparam int TID_W   = 4;
	localparam int PRIO_W  = 8;
	localparam int SCORE_W = PRIO_W + 1;
	localparam int TIME_W  = 32;
	localparam int OP_W    = 3;
	localparam int ST_W    = 2;
	localparam int MODE_W  = 3;

	localparam logic [PRIO_W-1:0] AGE_MAX = 8'd255;

	typedef logic [OP_W-1:0]   opcode_t;
	typedef logic [ST_W-1:0]   status_t;
	typedef logic [MODE_W-1:0] mode_t;

	localparam opcode_t OP_ADD    = 3'd0;
	localparam opcode_t OP_YIELD  = 3'd1;
	localparam opcode_t OP_SLEEP  = 3'd2;
	localparam opcode_t OP_MUTE   = 3'd3;
	localparam opcode_t OP_REMOVE = 3'd4;
	localparam opcode_t OP_RUN    = 3'd5;

	localparam status_t ST_DONE    = 2'd0;
	localparam status_t ST_IGNORED = 2'd1;
	localparam status_t ST_QUEUED  = 2'd2;
	localparam status_t ST_FULL    = 2'd3;

	localparam mode_t MODE_IDLE  = 3'd0;
	localparam mode_t MODE_READY = 3'd1;
	localparam mode_t MODE_SLEEP = 3'd2;
	localparam mode_t MODE_RUN   = 3'd3;
	localparam mode_t MODE_MUTE  = 3'd4;

	typedef struct packed {
		logic load;
		logic exec;
		logic idx_clr;
		logic idx_inc;
		logic slp_move;
		logic rdy_drop;
		logic scan;
		logic grant;
		logic rem_fin;
		logic out_load;
		logic list_last;
		logic task_by_id;
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    tid_ok;
		logic    slp_end;
		logic    slp_hit;
		logic    rdy_end;
		logic    rdy_hit;
		logic    can_grant;
	} sts_t;

endpackage

[rtl/core/aging_priority_task_scheduler_unit.sv]
// Top level of the aging priority task scheduler: controller, datapath and checks.
// Add, yield, sleep, mute and ignored items are executed once and go straight to the result.
// Remove walks the sleeper list and then the ready list to drop the task; run moves due sleepers
// to the ready list, then scans it and grants the best task if none is running and one is ready.
// One item is in work at a time; the next one is accepted the cycle after the result loads.
// Asynchronous reset empties both lists, sets every task idle and drops the running task.
`timescale 1ns / 1ps
module aging_priority_task_scheduler_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [apts_pkg::OP_W-1:0]     opcode,
	input  logic [apts_pkg::TID_W-1:0]    task_id,
	input  logic [apts_pkg::PRIO_W-1:0]   priority_req,
	input  logic [apts_pkg::TIME_W-1:0]   sleep_ms,
	input  logic [apts_pkg::TIME_W-1:0]   now_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          grant_valid,
	output logic [apts_pkg::TID_W-1:0]    grant_task,
	output logic [apts_pkg::ST_W-1:0]     status
);
	import apts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	apts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	apts_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (opcode),
		.task_id      (task_id),
		.priority_req (priority_req),
		.sleep_ms     (sleep_ms),
		.now_ms       (now_ms),
		.grant_valid  (grant_valid),
		.grant_task   (grant_task),
		.status       (status)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while previous item still in work");

	a_grant_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && grant_valid |-> status == ST_DONE)
		else $error("grant reported with a non-done status");

	a_single_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.exec, cmd.slp_move, cmd.rdy_drop, cmd.scan, cmd.grant, cmd.rem_fin}))
		else $error("more than one table update in one cycle");

	a_load_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("result load did not raise out_valid");

endmodule

[rtl/core/apts_ctrl.sv]
// Sequencing state machine for the task scheduler.
`timescale 1ns / 1ps
module apts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  apts_pkg::sts_t sts,
	output apts_pkg::cmd_t cmd
);
	import apts_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_EXEC     = 10'b00_0000_0010,
		S_SLP_CHK  = 10'b00_0000_0100,
		S_SLP_MOV  = 10'b00_0000_1000,
		S_RDY_FIND = 10'b00_0001_0000,
		S_RDY_DROP = 10'b00_0010_0000,
		S_REM_FIN  = 10'b00_0100_0000,
		S_SCAN     = 10'b00_1000_0000,
		S_GRANT    = 10'b01_0000_0000,
		S_DONE     = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec       = 1'b1;
				cmd.task_by_id = 1'b1;
				cmd.idx_clr    = 1'b1;
				if ((sts.op == OP_REMOVE && sts.tid_ok) || sts.op == OP_RUN) begin
					state_d = S_SLP_CHK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SLP_CHK: begin
				if (sts.slp_end) begin
					cmd.idx_clr = 1'b1;
					if (sts.op == OP_REMOVE) begin
						state_d = S_RDY_FIND;
					end else if (sts.can_grant) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end else if (sts.slp_hit) begin
					state_d = S_SLP_MOV;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SLP_MOV: begin
				cmd.list_last = 1'b1;
				cmd.slp_move  = 1'b1;
				state_d       = S_SLP_CHK;
			end
			S_RDY_FIND: begin
				if (sts.rdy_end) begin
					state_d = S_REM_FIN;
				end else if (sts.rdy_hit) begin
					state_d = S_RDY_DROP;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_RDY_DROP: begin
				cmd.list_last = 1'b1;
				cmd.rdy_drop  = 1'b1;
				state_d       = S_REM_FIN;
			end
			S_REM_FIN: begin
				cmd.rem_fin = 1'b1;
				state_d     = S_DONE;
			end
			S_SCAN: begin
				if (sts.rdy_end) begin
					state_d = S_GRANT;
				end else begin
					cmd.scan    = 1'b1;
					cmd.idx_inc = 1'b1;
				end
			end
			S_GRANT: begin
				cmd.list_last = 1'b1;
				cmd.grant     = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/apts_dp.sv]
// Task tables, ready and sleeper lists, scan unit and result registers of the task scheduler.
`timescale 1ns / 1ps
module apts_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  apts_pkg::cmd_t                cmd,
	output apts_pkg::sts_t                sts,
	input  logic [apts_pkg::OP_W-1:0]     opcode,
	input  logic [apts_pkg::TID_W-1:0]    task_id,
	input  logic [apts_pkg::PRIO_W-1:0]   priority_req,
	input  logic [apts_pkg::TIME_W-1:0]   sleep_ms,
	input  logic [apts_pkg::TIME_W-1:0]   now_ms,
	output logic                          grant_valid,
	output logic [apts_pkg::TID_W-1:0]    grant_task,
	output logic [apts_pkg::ST_W-1:0]     status
);
	import apts_pkg::*;

	opcode_t             op_q;
	logic [TID_W-1:0]    tid_q;
	logic [PRIO_W-1:0]   preq_q;
	logic [TIME_W-1:0]   ms_q;
	logic [TIME_W-1:0]   now_q;

	logic [TID_W-1:0]    rdy_q       [TASKS];
	logic [TID_W-1:0]    slp_task_q  [TASKS];
	logic [TIME_W-1:0]   slp_wake_q  [TASKS];
	mode_t               mode_q      [TASKS];
	logic [PRIO_W-1:0]   prio_q      [TASKS];
	logic [PRIO_W-1:0]   age_q       [TASKS];
	logic [CNT_W-1:0]    rdy_cnt_q;
	logic [CNT_W-1:0]    slp_cnt_q;
	logic                run_valid_q;
	logic [TID_W-1:0]    run_task_q;

	logic [CNT_W-1:0]    idx_q;
	logic [TID_W-1:0]    hit_task_q;
	logic [SCORE_W-1:0]  best_score_q;
	logic [SLOT_W-1:0]   best_idx_q;
	logic [TID_W-1:0]    best_task_q;

	logic                res_gv_q;
	logic [TID_W-1:0]    res_gt_q;
	status_t             res_st_q;

	logic [CNT_W-1:0]    rdy_dec;
	logic [CNT_W-1:0]    slp_dec;
	logic [SLOT_W-1:0]   idx_slot;
	logic [SLOT_W-1:0]   rdy_addr;
	logic [SLOT_W-1:0]   slp_addr;
	logic [SLOT_W-1:0]   rdy_tail;
	logic [SLOT_W-1:0]   slp_tail;
	logic [SLOT_W-1:0]   task_addr;
	logic [SLOT_W-1:0]   tid_slot;
	logic [SLOT_W-1:0]   run_slot;
	logic [SLOT_W-1:0]   hit_slot;
	logic [SLOT_W-1:0]   best_slot;
	logic [TID_W-1:0]    rdy_rd;
	logic [TID_W-1:0]    slp_task_rd;
	logic [TIME_W-1:0]   slp_wake_rd;
	logic [TIME_W-1:0]   wake_diff;
	logic [TIME_W-1:0]   wake_time;
	mode_t               mode_rd;
	logic [PRIO_W-1:0]   age_rd;
	logic [SCORE_W-1:0]  score;
	logic                tid_ok;
	logic                rdy_room;
	logic                slp_room;
	logic                wake_push;
	logic                add_do;
	logic                yield_do;
	logic                sleep_do;
	logic                mute_do;
	status_t             ex_st;

	assign rdy_dec   = rdy_cnt_q - CNT_W'(1);
	assign slp_dec   = slp_cnt_q - CNT_W'(1);
	assign idx_slot  = idx_q[SLOT_W-1:0];
	assign rdy_tail  = rdy_cnt_q[SLOT_W-1:0];
	assign slp_tail  = slp_cnt_q[SLOT_W-1:0];
	assign rdy_addr  = cmd.list_last ? rdy_dec[SLOT_W-1:0] : idx_slot;
	assign slp_addr  = cmd.list_last ? slp_dec[SLOT_W-1:0] : idx_slot;
	assign rdy_rd    = rdy_q[rdy_addr];
	assign slp_task_rd = slp_task_q[slp_addr];
	assign slp_wake_rd = slp_wake_q[slp_addr];
	assign tid_slot  = SLOT_W'(tid_q);
	assign run_slot  = SLOT_W'(run_task_q);
	assign hit_slot  = SLOT_W'(hit_task_q);
	assign best_slot = SLOT_W'(best_task_q);
	assign task_addr = cmd.task_by_id ? tid_slot : SLOT_W'(rdy_rd);
	assign mode_rd   = mode_q[task_addr];
	assign age_rd    = age_q[task_addr];
	assign score     = {1'b0, prio_q[task_addr]} + {1'b0, age_rd};
	assign tid_ok    = 32'(tid_q) < TASKS;
	assign rdy_room  = rdy_cnt_q < CNT_W'(TASKS);
	assign slp_room  = slp_cnt_q < CNT_W'(TASKS);
	assign wake_diff = now_q - slp_wake_rd;
	assign wake_time = now_q + ms_q;
	assign wake_push = cmd.slp_move && (op_q == OP_RUN);

	assign sts.op        = op_q;
	assign sts.tid_ok    = tid_ok;
	assign sts.slp_end   = idx_q >= slp_cnt_q;
	assign sts.slp_hit   = (op_q == OP_REMOVE) ? (slp_task_rd == tid_q)
	                                           : (!wake_diff[TIME_W-1] && rdy_room);
	assign sts.rdy_end   = idx_q >= rdy_cnt_q;
	assign sts.rdy_hit   = rdy_rd == tid_q;
	assign sts.can_grant = !run_valid_q && (rdy_cnt_q != '0);

	always_comb begin
		ex_st    = ST_DONE;
		add_do   = 1'b0;
		yield_do = 1'b0;
		sleep_do = 1'b0;
		mute_do  = 1'b0;
		case (op_q)
			OP_ADD: begin
				if (!tid_ok) ex_st = ST_IGNORED;
				else if (mode_rd != MODE_IDLE) ex_st = ST_QUEUED;
				else if (!rdy_room) ex_st = ST_FULL;
				else add_do = cmd.exec;
			end
			OP_YIELD: begin
				if (!run_valid_q) ex_st = ST_IGNORED;
				else if (!rdy_room) ex_st = ST_FULL;
				else yield_do = cmd.exec;
			end
			OP_SLEEP: begin
				if (!run_valid_q) ex_st = ST_IGNORED;
				else if (!slp_room) ex_st = ST_FULL;
				else sleep_do = cmd.exec;
			end
			OP_MUTE: begin
				if (!run_valid_q) ex_st = ST_IGNORED;
				else mute_do = cmd.exec;
			end
			OP_REMOVE: begin
				if (!tid_ok) ex_st = ST_IGNORED;
			end
			OP_RUN: begin
				ex_st = ST_DONE;
			end
			default: begin
				ex_st = ST_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			tid_q  <= task_id;
			preq_q <= priority_req;
			ms_q   <= sleep_ms;
			now_q  <= now_ms;
		end
		hit_task_q <= slp_task_rd;
		if (cmd.scan && (idx_q == '0 || score > best_score_q)) begin
			best_score_q <= score;
			best_idx_q   <= idx_slot;
			best_task_q  <= rdy_rd;
		end
		if (add_do) begin
			rdy_q[rdy_tail] <= tid_q;
		end else if (yield_do) begin
			rdy_q[rdy_tail] <= run_task_q;
		end else if (wake_push) begin
			rdy_q[rdy_tail] <= hit_task_q;
		end else if (cmd.rdy_drop) begin
			rdy_q[idx_slot] <= rdy_rd;
		end else if (cmd.grant) begin
			rdy_q[best_idx_q] <= rdy_rd;
		end
		if (sleep_do) begin
			slp_task_q[slp_tail] <= run_task_q;
			slp_wake_q[slp_tail] <= wake_time;
		end else if (cmd.slp_move) begin
			slp_task_q[idx_slot] <= slp_task_rd;
			slp_wake_q[idx_slot] <= slp_wake_rd;
		end
		if (cmd.exec) begin
			res_gv_q <= 1'b0;
			res_gt_q <= '0;
			res_st_q <= ex_st;
		end else if (cmd.grant) begin
			res_gv_q <= 1'b1;
			res_gt_q <= best_task_q;
		end
		if (cmd.out_load) begin
			grant_valid <= res_gv_q;
			grant_task  <= res_gt_q;
			status      <= res_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_cnt_q   <= '0;
			slp_cnt_q   <= '0;
			run_valid_q <= 1'b0;
			run_task_q  <= '0;
			idx_q       <= '0;
			for (int i = 0; i < TASKS; i++) begin
				mode_q[i] <= MODE_IDLE;
				prio_q[i] <= '0;
				age_q[i]  <= '0;
			end
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (add_do || yield_do || wake_push) begin
				rdy_cnt_q <= rdy_cnt_q + CNT_W'(1);
			end else if (cmd.rdy_drop || cmd.grant) begin
				rdy_cnt_q <= rdy_dec;
			end
			if (sleep_do) begin
				slp_cnt_q <= slp_cnt_q + CNT_W'(1);
			end else if (cmd.slp_move) begin
				slp_cnt_q <= slp_dec;
			end
			if (add_do) begin
				mode_q[tid_slot] <= MODE_READY;
				prio_q[tid_slot] <= preq_q;
				age_q[tid_slot]  <= '0;
			end else if (yield_do) begin
				mode_q[run_slot] <= MODE_READY;
				run_valid_q      <= 1'b0;
			end else if (sleep_do) begin
				mode_q[run_slot] <= MODE_SLEEP;
				run_valid_q      <= 1'b0;
			end else if (mute_do) begin
				mode_q[run_slot] <= MODE_MUTE;
				run_valid_q      <= 1'b0;
			end else if (wake_push) begin
				mode_q[hit_slot] <= MODE_READY;
			end else if (cmd.scan) begin
				if (age_rd != AGE_MAX) begin
					age_q[task_addr] <= age_rd + PRIO_W'(1);
				end
			end else if (cmd.grant) begin
				mode_q[best_slot] <= MODE_RUN;
				age_q[best_slot]  <= '0;
				run_valid_q       <= 1'b1;
				run_task_q        <= best_task_q;
			end else if (cmd.rem_fin) begin
				mode_q[tid_slot] <= MODE_IDLE;
				prio_q[tid_slot] <= '0;
				age_q[tid_slot]  <= '0;
				if (run_task_q == tid_q) begin
					run_valid_q <= 1'b0;
				end
			end
		end
	end

endmodule
